// ===== design/vna_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the vertex normal accumulator.
// Depends on nothing; used by vertex_normal_accumulator_unit.
package vna_pkg;

	localparam int ACC_W = 48;
	localparam int OUT_W = 16;
	localparam int IDX_W = 10;
	localparam int POS_IN_W = 20;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_TRI   = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRI_RD,
		ST_TRI_MUL,
		ST_TRI_ACC,
		ST_NRM_RD,
		ST_NRM_SHIFT,
		ST_NRM_SQ,
		ST_NRM_SQRT,
		ST_NRM_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== design/vertex_normal_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Area-weighted vertex normal accumulator: position store, accumulator store and one
// shared multiplier, square root and divider step under a sequencer. Uses vna_pkg.
//
// The block takes one word at a time and is not ready until it has finished it. A load
// position is written into the position store as it is taken. After reset, and for every
// clear, the accumulator memory is swept one entry per cycle, during which no word is taken.
// An add triangle does three position reads, six cross-product multiplies on the one
// multiplier and a read-modify-write per corner on the single-port accumulator memory. A
// read normal does one-bit normalizing shifts, the squares, a bit-serial square root and
// three 15-step divisions; an out-of-range or zero read skips the arithmetic. One result
// is held at the output while the next word is taken.
module vertex_normal_accumulator_unit #(
	parameter int MAX_VERTICES = 1024,
	parameter int POSITION_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero fill
	input  logic [103:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]  m_axis_tdata,
	// zero_length
	output logic [0:0]   m_axis_tuser
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int PB = POSITION_BITS;
	localparam int MW = (PB + 1 > 32) ? PB + 1 : 32;
	localparam int PW = 2 * MW;
	localparam int XW = (PW + 1 > 49) ? PW + 1 : 49;
	localparam int AC = vna_pkg::ACC_W;
	localparam int OW = vna_pkg::OUT_W;

	vna_pkg::state_t state_q, state_d;
	logic [5:0]   step_q;
	logic [AW-1:0] clr_q;
	logic         m_valid_q;

	logic [3*PB-1:0] pos_mem [MAX_VERTICES];
	logic [3*AC-1:0] acc_mem [MAX_VERTICES];
	logic [3*PB-1:0] pos_rd_q;
	logic [3*AC-1:0] acc_rd_q;
	logic [AW-1:0]   pos_addr, acc_addr;
	logic            pos_we, acc_we;
	logic [3*AC-1:0] acc_wd;

	logic [9:0]  in_vi, in_ca, in_cb, in_cc;
	logic [1:0]  in_op;
	logic        accept, vi_ok, tri_ok;
	logic [AW-1:0] vi_q, ca_q, cb_q, cc_q;

	logic [3*PB-1:0] pa_q, pb_q;
	logic signed [MW-1:0] e1_q [3];
	logic signed [MW-1:0] e2_q [3];
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, t_q;
	logic [AC-1:0] n_q [3];
	logic signed [XW-1:0] dx;
	logic [AC-1:0] cross_sat;

	logic [AC-1:0] mag_q [3];
	logic [2:0]    sgn_q;
	logic [AC-1:0] or_v;
	logic [63:0]   sum_q, sn_q, sr_q, sb_q, sq_t;
	logic [46:0]   num_q, den_q;
	logic [13:0]   q_q;
	logic          dv_ge;
	logic [14:0]   q_fin;
	logic [1:0]    comp;
	logic [OW-1:0] res_q [3];
	logic          res_zero_q;
	logic [47:0]   out_data_q;
	logic          out_zero_q;
	logic          acc_zero;

	function automatic logic [AC-1:0] acc_sat(input logic [AC-1:0] a, input logic [AC-1:0] b);
		logic [AC:0] s;
		s = {a[AC-1], a} + {b[AC-1], b};
		if (s[AC] != s[AC-1]) begin
			return s[AC] ? vna_pkg::ACC_MIN : vna_pkg::ACC_MAX;
		end
		return s[AC-1:0];
	endfunction

	function automatic logic signed [MW-1:0] pos_ext(input logic [PB-1:0] p);
		return $signed({{(MW-PB){p[PB-1]}}, p});
	endfunction

	assign in_vi = s_axis_tdata[9:0];
	assign in_ca = s_axis_tdata[79:70];
	assign in_cb = s_axis_tdata[89:80];
	assign in_cc = s_axis_tdata[99:90];
	assign in_op = s_axis_tuser;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign vi_ok = {22'd0, in_vi} < 32'(MAX_VERTICES);
	assign tri_ok = ({22'd0, in_ca} < 32'(MAX_VERTICES)) && ({22'd0, in_cb} < 32'(MAX_VERTICES))
		&& ({22'd0, in_cc} < 32'(MAX_VERTICES));
	assign s_axis_tready = (state_q == vna_pkg::ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_zero_q;

	assign acc_zero = (acc_rd_q == '0);
	assign or_v = mag_q[0] | mag_q[1] | mag_q[2];
	assign sq_t = sr_q + sb_q;
	assign dv_ge = (num_q >= den_q);
	assign q_fin = {q_q, dv_ge};
	assign comp = step_q[5:4];

	always_comb begin
		dx = $signed({{(XW-PW){t_q[PW-1]}}, t_q}) - $signed({{(XW-PW){prod_q[PW-1]}}, prod_q});
		if (dx > $signed({{(XW-AC){1'b0}}, vna_pkg::ACC_MAX})) begin
			cross_sat = vna_pkg::ACC_MAX;
		end else if (dx < $signed({{(XW-AC){1'b1}}, vna_pkg::ACC_MIN})) begin
			cross_sat = vna_pkg::ACC_MIN;
		end else begin
			cross_sat = dx[AC-1:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == vna_pkg::ST_TRI_MUL) begin
			case (step_q[2:0])
				3'd0: begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
				3'd1: begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
				3'd2: begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
				3'd3: begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
				3'd4: begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
				3'd5: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == vna_pkg::ST_NRM_SQ && step_q[1:0] != 2'd3) begin
			mul_a = $signed({{(MW-31){1'b0}}, mag_q[step_q[1:0]][30:0]});
			mul_b = mul_a;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vna_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAX_VERTICES - 1)) state_d = vna_pkg::ST_IDLE;
			end
			vna_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					case (in_op)
						vna_pkg::OP_CLEAR: state_d = vna_pkg::ST_CLEAR;
						vna_pkg::OP_TRI: state_d = tri_ok ? vna_pkg::ST_TRI_RD : vna_pkg::ST_IDLE;
						vna_pkg::OP_READ: state_d = vi_ok ? vna_pkg::ST_NRM_RD : vna_pkg::ST_DONE;
						default: state_d = vna_pkg::ST_IDLE;
					endcase
				end
			end
			vna_pkg::ST_TRI_RD: if (step_q == 6'd4) state_d = vna_pkg::ST_TRI_MUL;
			vna_pkg::ST_TRI_MUL: if (step_q == 6'd6) state_d = vna_pkg::ST_TRI_ACC;
			vna_pkg::ST_TRI_ACC: if (step_q == 6'd5) state_d = vna_pkg::ST_IDLE;
			vna_pkg::ST_NRM_RD: begin
				if (step_q == 6'd1) state_d = acc_zero ? vna_pkg::ST_DONE : vna_pkg::ST_NRM_SHIFT;
			end
			vna_pkg::ST_NRM_SHIFT: begin
				if (or_v[AC-1:31] == '0 && or_v[30]) state_d = vna_pkg::ST_NRM_SQ;
			end
			vna_pkg::ST_NRM_SQ: if (step_q == 6'd3) state_d = vna_pkg::ST_NRM_SQRT;
			vna_pkg::ST_NRM_SQRT: if (step_q == 6'd32) state_d = vna_pkg::ST_NRM_DIV;
			vna_pkg::ST_NRM_DIV: if (step_q == 6'd47) state_d = vna_pkg::ST_DONE;
			vna_pkg::ST_DONE: if (!m_valid_q || m_axis_tready) state_d = vna_pkg::ST_IDLE;
			default: state_d = vna_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pos_addr = AW'(in_vi);
		pos_we = 1'b0;
		acc_addr = vi_q;
		acc_we = 1'b0;
		acc_wd = '0;
		case (state_q)
			vna_pkg::ST_CLEAR: begin
				acc_addr = clr_q;
				acc_we = 1'b1;
			end
			vna_pkg::ST_IDLE: begin
				pos_we = accept && (in_op == vna_pkg::OP_LOAD) && vi_ok;
			end
			vna_pkg::ST_TRI_RD: begin
				case (step_q[1:0])
					2'd0: pos_addr = ca_q;
					2'd1: pos_addr = cb_q;
					default: pos_addr = cc_q;
				endcase
			end
			vna_pkg::ST_TRI_ACC: begin
				case (step_q[2:1])
					2'd0: acc_addr = ca_q;
					2'd1: acc_addr = cb_q;
					default: acc_addr = cc_q;
				endcase
				acc_we = step_q[0];
				acc_wd = {acc_sat(acc_rd_q[3*AC-1:2*AC], n_q[2]),
					acc_sat(acc_rd_q[2*AC-1:AC], n_q[1]), acc_sat(acc_rd_q[AC-1:0], n_q[0])};
			end
			default: begin
				acc_addr = vi_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_addr] <= {PB'(s_axis_tdata[69:50]), PB'(s_axis_tdata[49:30]),
				PB'(s_axis_tdata[29:10])};
		end
		pos_rd_q <= pos_mem[pos_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_addr] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vna_pkg::ST_CLEAR;
			step_q <= '0;
			clr_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= (state_d != state_q) ? 6'd0 : step_q + 6'd1;
			clr_q <= (state_q == vna_pkg::ST_CLEAR) ? clr_q + AW'(1) : '0;
			if (state_q == vna_pkg::ST_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_a != '0 || mul_b != '0 || state_q == vna_pkg::ST_TRI_MUL
				|| state_q == vna_pkg::ST_NRM_SQ) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			vna_pkg::ST_IDLE: begin
				vi_q <= AW'(in_vi);
				ca_q <= AW'(in_ca);
				cb_q <= AW'(in_cb);
				cc_q <= AW'(in_cc);
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
				res_zero_q <= 1'b1;
			end
			vna_pkg::ST_TRI_RD: begin
				if (step_q == 6'd1) pa_q <= pos_rd_q;
				if (step_q == 6'd2) pb_q <= pos_rd_q;
				if (step_q == 6'd3) begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= pos_ext(pb_q[i*PB +: PB]) - pos_ext(pa_q[i*PB +: PB]);
						e2_q[i] <= pos_ext(pos_rd_q[i*PB +: PB]) - pos_ext(pa_q[i*PB +: PB]);
					end
				end
			end
			vna_pkg::ST_TRI_MUL: begin
				if (step_q != 6'd0) begin
					if (step_q[0]) begin
						t_q <= prod_q;
					end else begin
						n_q[step_q[2:1] - 2'd1] <= cross_sat;
					end
				end
			end
			vna_pkg::ST_NRM_RD: begin
				for (int i = 0; i < 3; i++) begin
					sgn_q[i] <= acc_rd_q[i*AC + AC - 1];
					mag_q[i] <= acc_rd_q[i*AC + AC - 1] ? -acc_rd_q[i*AC +: AC]
						: acc_rd_q[i*AC +: AC];
				end
			end
			vna_pkg::ST_NRM_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (or_v[AC-1:31] != '0) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (!or_v[30]) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			vna_pkg::ST_NRM_SQ: begin
				if (step_q != 6'd0) begin
					sum_q <= ((step_q == 6'd1) ? 64'd0 : sum_q) + prod_q[63:0];
				end
			end
			vna_pkg::ST_NRM_SQRT: begin
				if (step_q == 6'd0) begin
					sn_q <= sum_q;
					sr_q <= '0;
					sb_q <= 64'd1 << 62;
				end else begin
					if (sn_q >= sq_t) begin
						sn_q <= sn_q - sq_t;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q <= sb_q >> 2;
				end
			end
			vna_pkg::ST_NRM_DIV: begin
				if (step_q[3:0] == 4'd0) begin
					num_q <= {1'b0, mag_q[comp][30:0], 15'd0} + {15'd0, sr_q[31:0]};
					den_q <= {sr_q[31:0], 15'd0};
					q_q <= '0;
				end else begin
					if (dv_ge) num_q <= num_q - den_q;
					den_q <= den_q >> 1;
					q_q <= q_fin[13:0];
					if (step_q[3:0] == 4'd15) begin
						res_q[comp] <= sgn_q[comp] ? -{1'b0, q_fin} : {1'b0, q_fin};
						res_zero_q <= 1'b0;
					end
				end
			end
			vna_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					out_data_q <= {res_q[2], res_q[1], res_q[0]};
					out_zero_q <= res_zero_q;
				end
			end
			default: begin
				out_zero_q <= out_zero_q;
			end
		endcase
	end

endmodule

// ===== dv/vna_checker.sv =====
`timescale 1ns / 1ps
// Checker for vertex_normal_accumulator_unit: watches both stream channels, predicts each
// normal read and compares it field by field. Uses vna_pkg.
module vna_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [47:0]  m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	output int           fail_count,
	output int           pending,
	output int           normals_seen
);

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        zl;
	} unit_normal_t;

	logic signed [19:0] vert_x [1024];
	logic signed [19:0] vert_y [1024];
	logic signed [19:0] vert_z [1024];
	logic signed [47:0] sum_x [1024];
	logic signed [47:0] sum_y [1024];
	logic signed [47:0] sum_z [1024];
	unit_normal_t normal_queue [$];

	function automatic logic signed [47:0] clamp48(longint v);
		if (v > 64'sh00007FFFFFFFFFFF) return vna_pkg::ACC_MAX;
		if (v < -64'sh0000800000000000) return vna_pkg::ACC_MIN;
		return v[47:0];
	endfunction

	function automatic logic signed [47:0] sat_add(logic signed [47:0] a, logic signed [47:0] b);
		longint t;
		t = longint'(a) + longint'(b);
		return clamp48(t);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000000000000000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic unit_normal_t unit_of(logic signed [47:0] sx, logic signed [47:0] sy,
			logic signed [47:0] sz);
		longint s [3];
		longint unsigned m [3];
		longint unsigned big, sq, len, q;
		int bl;
		unit_normal_t r;
		s[0] = sx; s[1] = sy; s[2] = sz;
		big = 0;
		sq = 0;
		r = '{nx: 16'd0, ny: 16'd0, nz: 16'd0, zl: 1'b1};
		for (int i = 0; i < 3; i++) begin
			m[i] = s[i] < 0 ? -s[i] : s[i];
			if (m[i] > big) big = m[i];
		end
		if (big == 0) return r;
		bl = 0;
		while ((big >> bl) != 0) bl++;
		for (int i = 0; i < 3; i++) begin
			if (bl > 31) m[i] >>= (bl - 31);
			else m[i] <<= (31 - bl);
			sq += m[i] * m[i];
		end
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd32768 + len) / (64'd2 * len);
			if (s[i] < 0) q = -q;
			if (i == 0) r.nx = q[15:0];
			else if (i == 1) r.ny = q[15:0];
			else r.nz = q[15:0];
		end
		r.zl = 1'b0;
		return r;
	endfunction

	task automatic absorb_word(logic [1:0] op, logic [103:0] d);
		int vi, a, b, c;
		longint e1x, e1y, e1z, e2x, e2y, e2z;
		logic signed [47:0] nx, ny, nz;
		vi = d[9:0];
		a = d[79:70];
		b = d[89:80];
		c = d[99:90];
		case (op)
			vna_pkg::OP_CLEAR: begin
				for (int i = 0; i < 1024; i++) begin
					sum_x[i] = '0; sum_y[i] = '0; sum_z[i] = '0;
				end
			end
			vna_pkg::OP_LOAD: begin
				vert_x[vi] = d[29:10];
				vert_y[vi] = d[49:30];
				vert_z[vi] = d[69:50];
			end
			vna_pkg::OP_TRI: begin
				e1x = longint'(vert_x[b]) - longint'(vert_x[a]);
				e1y = longint'(vert_y[b]) - longint'(vert_y[a]);
				e1z = longint'(vert_z[b]) - longint'(vert_z[a]);
				e2x = longint'(vert_x[c]) - longint'(vert_x[a]);
				e2y = longint'(vert_y[c]) - longint'(vert_y[a]);
				e2z = longint'(vert_z[c]) - longint'(vert_z[a]);
				nx = clamp48(e1y * e2z - e1z * e2y);
				ny = clamp48(e1z * e2x - e1x * e2z);
				nz = clamp48(e1x * e2y - e1y * e2x);
				foreach (vert_x[k]) begin
					if (k == a || k == b || k == c) begin
						for (int rep = 0; rep < 3; rep++) begin
							if ((rep == 0 && k == a) || (rep == 1 && k == b)
									|| (rep == 2 && k == c)) begin
								sum_x[k] = sat_add(sum_x[k], nx);
								sum_y[k] = sat_add(sum_y[k], ny);
								sum_z[k] = sat_add(sum_z[k], nz);
							end
						end
					end
				end
			end
			vna_pkg::OP_READ: normal_queue.insert(normal_queue.size(),
				unit_of(sum_x[vi], sum_y[vi], sum_z[vi]));
			default: ;
		endcase
	endtask

	task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(got_v));
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		unit_normal_t e;
		if (!arst_n) begin
			fail_count = 0;
			normals_seen = 0;
			normal_queue.delete();
			for (int i = 0; i < 1024; i++) begin
				vert_x[i] = '0; vert_y[i] = '0; vert_z[i] = '0;
				sum_x[i] = '0; sum_y[i] = '0; sum_z[i] = '0;
			end
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				normals_seen++;
				if (normal_queue.size() == 0) begin
					$error("Unexpected normal word: no read is outstanding");
					fail_count++;
				end else begin
					e = normal_queue.pop_front();
					compare_field("normal_x", e.nx, m_axis_tdata[15:0]);
					compare_field("normal_y", e.ny, m_axis_tdata[31:16]);
					compare_field("normal_z", e.nz, m_axis_tdata[47:32]);
					compare_field("zero_length", {15'd0, e.zl}, {15'd0, m_axis_tuser[0]});
				end
			end
			if (s_axis_tvalid && s_axis_tready) absorb_word(s_axis_tuser, s_axis_tdata);
		end
		pending = normal_queue.size();
	end

	final begin
		if (normal_queue.size() != 0) $display("Outstanding normals at end: %0d", normal_queue.size());
	end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Top of the vertex normal accumulator testbench: clock, reset, word stimulus, receiver
// stalls and verdict. Depends on vna_pkg, vna_checker and vertex_normal_accumulator_unit.
module tb;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	int           fail_count, pending, normals_seen;
	int           burst_left;
	int           idle_cycles;
	int           op_count [4];
	logic         loaded [1024];
	int           loaded_list [$];

	vertex_normal_accumulator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	vna_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count), .pending(pending), .normals_seen(normals_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one word: raised at a falling edge, held until tready was seen before a rising edge.
	task automatic send_word(logic [1:0] op, logic [103:0] d);
		logic rdy;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		op_count[op]++;
		do begin
			rdy = s_axis_tready;
			@(negedge clk);
		end while (!rdy);
		if (op == vna_pkg::OP_LOAD && !loaded[d[9:0]]) begin
			loaded[d[9:0]] = 1'b1;
			loaded_list.insert(loaded_list.size(), int'(d[9:0]));
		end
	endtask

	function automatic logic [19:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 20'h7FFFF;
			1: return 20'h80000;
			2: return 20'(($urandom_range(0, 64)) - 32);
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [103:0] load_word(int vi, logic [19:0] x, logic [19:0] y,
			logic [19:0] z);
		return {34'd0, z, y, x, 10'(vi)};
	endfunction

	function automatic logic [103:0] tri_word(int a, int b, int c);
		return {4'd0, 10'(c), 10'(b), 10'(a), 70'd0};
	endfunction

	function automatic int pick_corner();
		int v;
		v = $urandom_range(0, 1023);
		if (loaded[v]) return v;
		if ($urandom_range(0, 1)) return loaded_list[$urandom_range(0, 7)];
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	// Receiver: its own stall pattern, plus one long hold-off while words keep coming.
	initial begin
		int cyc;
		int mode;
		m_axis_tready = 1'b0;
		cyc = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 400 == 0) mode = $urandom_range(0, 3);
			if (cyc >= 6000 && cyc < 9000) m_axis_tready <= 1'b0;
			else if (mode == 0) m_axis_tready <= 1'b1;
			else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
			else if (mode == 2) m_axis_tready <= ($urandom_range(0, 3) == 0);
			else m_axis_tready <= ((cyc % 37) < 20);
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 20000) begin
				$display("Watchdog: no word moved for %0d cycles", idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int op, wait_cycles;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = vna_pkg::OP_CLEAR;
		arst_n = 1'b0;
		burst_left = 0;
		foreach (loaded[i]) loaded[i] = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(vna_pkg::OP_READ, 104'd0);
		send_word(vna_pkg::OP_LOAD, load_word(0, 20'h00000, 20'h00000, 20'h00000));
		send_word(vna_pkg::OP_LOAD, load_word(1, 20'h7FFFF, 20'h80000, 20'h00000));
		send_word(vna_pkg::OP_LOAD, load_word(2, 20'h80000, 20'h7FFFF, 20'h7FFFF));
		send_word(vna_pkg::OP_LOAD, load_word(1023, 20'h80000, 20'h80000, 20'h80000));
		send_word(vna_pkg::OP_LOAD, load_word(3, 20'h01000, 20'h00000, 20'h00000));
		send_word(vna_pkg::OP_LOAD, load_word(4, 20'h00000, 20'h01000, 20'h00000));
		send_word(vna_pkg::OP_LOAD, load_word(5, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
		send_word(vna_pkg::OP_LOAD, load_word(6, 20'h55555, 20'hAAAAA, 20'h33333));
		send_word(vna_pkg::OP_LOAD, load_word(7, 20'hAAAAA, 20'h55555, 20'hCCCCC));
		send_word(vna_pkg::OP_TRI, tri_word(0, 3, 4));
		send_word(vna_pkg::OP_READ, 104'd3);
		send_word(vna_pkg::OP_TRI, tri_word(1, 1, 2));
		send_word(vna_pkg::OP_READ, 104'd1);
		for (int i = 0; i < 6; i++) send_word(vna_pkg::OP_TRI, tri_word(1, 2, 1023));
		send_word(vna_pkg::OP_TRI, tri_word(1023, 5, 1));
		send_word(vna_pkg::OP_TRI, tri_word(6, 7, 0));
		send_word(vna_pkg::OP_READ, 104'd1023);
		send_word(vna_pkg::OP_READ, 104'd2);
		send_word(vna_pkg::OP_READ, 104'd512);
		send_word(vna_pkg::OP_CLEAR, 104'd0);
		send_word(vna_pkg::OP_READ, 104'd1023);

		for (int n = 0; n < 1620; n++) begin
			op = $urandom_range(0, 99);
			if (op < 1)
				send_word(vna_pkg::OP_CLEAR, 104'({$urandom, $urandom, $urandom, $urandom}));
			else if (op < 25)
				send_word(vna_pkg::OP_LOAD, load_word($urandom_range(0, 1) ? $urandom_range(0, 15)
					: $urandom_range(0, 1023), pick_coord(), pick_coord(), pick_coord()));
			else if (op < 75)
				send_word(vna_pkg::OP_TRI, tri_word(pick_corner(), pick_corner(), pick_corner()));
			else
				send_word(vna_pkg::OP_READ, $urandom_range(0, 1) ? 104'(pick_corner())
					: 104'($urandom_range(0, 1023)));
		end
		s_axis_tvalid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 50000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (1200) @(negedge clk);
		$display("Sent %0d clears, %0d loads, %0d triangles, %0d reads; %0d normals checked.",
			op_count[vna_pkg::OP_CLEAR], op_count[vna_pkg::OP_LOAD], op_count[vna_pkg::OP_TRI],
			op_count[vna_pkg::OP_READ], normals_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("Failures: %0d, normals still outstanding: %0d", fail_count, pending);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
